// ===== hw/rtl/lrpw_pkg.sv =====
// Shared types and constants for the Bresenham line rasterizer / pixel writer.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package lrpw_pkg;

  // Clipping limits, framebuffer geometry and result widths
  localparam int unsigned ClipBits   = 13;
  localparam int unsigned BppBits    = 6;
  localparam int unsigned StrideBits = 16;
  localparam int unsigned ColorBits  = 24;
  localparam int unsigned AddrBits   = 28;
  localparam int unsigned ByteShift  = 3;   // bits per pixel -> bytes per pixel
  localparam int unsigned PaddrBits  = 4;
  localparam int unsigned PdataBits  = 32;

  // Register reset values
  localparam logic [ClipBits-1:0]   ScreenWidthRst  = 13'd1024;
  localparam logic [ClipBits-1:0]   ScreenHeightRst = 13'd768;
  localparam logic [BppBits-1:0]    BppRst          = 6'd32;
  localparam logic [StrideBits-1:0] LineStrideRst   = 16'd4096;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } lrpw_op_e;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH   = 2'd0,
    REG_SCREEN_HEIGHT  = 2'd1,
    REG_BITS_PER_PIXEL = 2'd2,
    REG_LINE_STRIDE    = 2'd3
  } lrpw_reg_e;

  // Status of the current point, handed from the stepper to the address path
  typedef struct packed {
    logic                in_bounds;  // pixel lies on screen and is written
    logic                line_done;  // point equals end point after this step
    logic [ClipBits-1:0] pix_x;      // column, meaningful when in_bounds
    logic [ClipBits-1:0] pix_y;      // row, meaningful when in_bounds
  } lrpw_pix_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lrpw_if.sv =====
// Valid/ready channel interfaces: command words in, pixel words out.
// Depends on lrpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lrpw_cmd_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                          valid;
  logic                          ready;
  lrpw_pkg::lrpw_op_e            opcode;
  logic signed [COORD_BITS-1:0]  start_x;
  logic signed [COORD_BITS-1:0]  start_y;
  logic signed [COORD_BITS-1:0]  end_x;
  logic signed [COORD_BITS-1:0]  end_y;
  logic [lrpw_pkg::ColorBits-1:0] line_color;

  modport source (output valid, opcode, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, line_color,
                  output ready);
endinterface

interface lrpw_pix_if;
  logic                           valid;
  logic                           ready;
  logic [lrpw_pkg::AddrBits-1:0]  byte_address;
  logic [lrpw_pkg::ColorBits-1:0] pixel_color;
  logic                           pixel_valid;
  logic                           line_done;

  modport source (output valid, byte_address, pixel_color, pixel_valid, line_done,
                  input ready);
  modport sink   (input valid, byte_address, pixel_color, pixel_valid, line_done,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lrpw_stepper.sv =====
// Bresenham state: current point, end point, spans, error term and directions.
// Reports the current pixel's clip status and takes one step per step word.
// Depends on lrpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrpw_stepper #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic                            step_i,
  input  logic signed [COORD_BITS-1:0]    start_x_i,
  input  logic signed [COORD_BITS-1:0]    start_y_i,
  input  logic signed [COORD_BITS-1:0]    end_x_i,
  input  logic signed [COORD_BITS-1:0]    end_y_i,
  input  logic [lrpw_pkg::ColorBits-1:0]  color_i,
  input  logic [lrpw_pkg::ClipBits-1:0]   screen_width_i,
  input  logic [lrpw_pkg::ClipBits-1:0]   screen_height_i,
  output lrpw_pkg::lrpw_pix_t             pix_o,
  output logic [lrpw_pkg::ColorBits-1:0]  color_o
);
  import lrpw_pkg::*;

  localparam int unsigned SpanW = COORD_BITS + 1;
  localparam int unsigned ErrW  = COORD_BITS + 3;
  localparam int unsigned CmpW  = (COORD_BITS > ClipBits) ? COORD_BITS : ClipBits;

  logic signed [COORD_BITS-1:0] point_x_q, point_y_q, target_x_q, target_y_q;
  logic signed [COORD_BITS-1:0] point_x_d, point_y_d;
  logic [SpanW-1:0]             span_x_q, span_y_q, span_x_d, span_y_d;
  logic signed [ErrW-1:0]       err_q, err_d, err_load;
  logic                         neg_x_q, neg_y_q;
  logic [ColorBits-1:0]         color_q;

  logic signed [SpanW-1:0]      diff_x, diff_y;
  logic signed [ErrW:0]         twice, sx_w, sy_w;
  logic                         move_x, move_y, at_end;
  logic [CmpW-1:0]              ext_x, ext_y;
  logic                         in_bounds;

  // Spans and initial error for a new line
  assign diff_x   = SpanW'(end_x_i) - SpanW'(start_x_i);
  assign diff_y   = SpanW'(end_y_i) - SpanW'(start_y_i);
  assign span_x_d = diff_x[SpanW-1] ? SpanW'(-diff_x) : SpanW'(diff_x);
  assign span_y_d = diff_y[SpanW-1] ? SpanW'(-diff_y) : SpanW'(diff_y);
  assign err_load = $signed(ErrW'(span_x_d)) - $signed(ErrW'(span_y_d));

  // One Bresenham step from the current state
  assign twice  = {err_q, 1'b0};
  assign sx_w   = $signed((ErrW + 1)'(span_x_q));
  assign sy_w   = $signed((ErrW + 1)'(span_y_q));
  assign move_x = twice > -sy_w;
  assign move_y = twice < sx_w;
  assign at_end = (point_x_q == target_x_q) && (point_y_q == target_y_q);

  always_comb begin
    err_d     = err_q;
    point_x_d = point_x_q;
    point_y_d = point_y_q;
    if (move_x) begin
      err_d     = err_d - ErrW'(sy_w);
      point_x_d = neg_x_q ? point_x_q - COORD_BITS'(1) : point_x_q + COORD_BITS'(1);
    end
    if (move_y) begin
      err_d     = err_d + ErrW'(sx_w);
      point_y_d = neg_y_q ? point_y_q - COORD_BITS'(1) : point_y_q + COORD_BITS'(1);
    end
  end

  // Clip test of the current point
  assign ext_x     = CmpW'(unsigned'(point_x_q));
  assign ext_y     = CmpW'(unsigned'(point_y_q));
  assign in_bounds = !point_x_q[COORD_BITS-1] && !point_y_q[COORD_BITS-1] &&
                     (ext_x < CmpW'(screen_width_i)) && (ext_y < CmpW'(screen_height_i));

  always_comb begin
    pix_o.in_bounds = in_bounds && !at_end;
    pix_o.line_done = at_end || ((point_x_d == target_x_q) && (point_y_d == target_y_q));
    pix_o.pix_x     = ext_x[ClipBits-1:0];
    pix_o.pix_y     = ext_y[ClipBits-1:0];
  end

  assign color_o = color_q;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_x_q  <= '0;
      point_y_q  <= '0;
      target_x_q <= '0;
      target_y_q <= '0;
      span_x_q   <= '0;
      span_y_q   <= '0;
      err_q      <= '0;
      neg_x_q    <= 1'b0;
      neg_y_q    <= 1'b0;
      color_q    <= '0;
    end else if (load_i) begin
      point_x_q  <= start_x_i;
      point_y_q  <= start_y_i;
      target_x_q <= end_x_i;
      target_y_q <= end_y_i;
      span_x_q   <= span_x_d;
      span_y_q   <= span_y_d;
      err_q      <= err_load;
      neg_x_q    <= diff_x[SpanW-1];
      neg_y_q    <= diff_y[SpanW-1];
      color_q    <= color_i;
    end else if (step_i && !at_end) begin
      point_x_q  <= point_x_d;
      point_y_q  <= point_y_d;
      err_q      <= err_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/line_rasterizer_pixel_writer_unit.sv =====
// A step word accepted on the command port passes the products stage, then the output
// stage, before it is offered on the pixel port.
// Throughput: one word per cycle while the pixel port is not stalled.
// Load words produce no pixel word. Address path: multiply stage, then add stage.
// Reset (rst_ni low, async): line state cleared, pipeline empty, registers to
// width 1024, height 768, 32 bits per pixel, stride 4096.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_pixel_writer_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lrpw_cmd_if.sink                         cmd_i,
  lrpw_pix_if.source                       pix_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lrpw_pkg::PaddrBits-1:0]   paddr,
  input  logic [lrpw_pkg::PdataBits-1:0]   pwdata,
  output logic [lrpw_pkg::PdataBits-1:0]   prdata,
  output logic                             pready
);
  import lrpw_pkg::*;

  localparam int unsigned XprodW = ClipBits + BppBits;
  localparam int unsigned YprodW = ClipBits + StrideBits;

  // Configuration registers
  logic [ClipBits-1:0]   width_q, height_q;
  logic [BppBits-1:0]    bpp_q;
  logic [StrideBits-1:0] stride_q;
  lrpw_reg_e             reg_idx;
  logic                  cfg_wr;

  assign reg_idx = lrpw_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ScreenWidthRst;
      height_q <= ScreenHeightRst;
      bpp_q    <= BppRst;
      stride_q <= LineStrideRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SCREEN_WIDTH:   width_q  <= pwdata[ClipBits-1:0];
        REG_SCREEN_HEIGHT:  height_q <= pwdata[ClipBits-1:0];
        REG_BITS_PER_PIXEL: bpp_q    <= pwdata[BppBits-1:0];
        REG_LINE_STRIDE:    stride_q <= pwdata[StrideBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCREEN_WIDTH:   prdata = PdataBits'(width_q);
      REG_SCREEN_HEIGHT:  prdata = PdataBits'(height_q);
      REG_BITS_PER_PIXEL: prdata = PdataBits'(bpp_q);
      REG_LINE_STRIDE:    prdata = PdataBits'(stride_q);
      default:            prdata = '0;
    endcase
  end

  // Handshake: each stage moves when the one after it is empty or moving
  logic v1_q, vo_q, adv_o, adv_1, accept, do_load, do_step;

  assign adv_o       = !vo_q || pix_o.ready;
  assign adv_1       = !v1_q || adv_o;
  assign cmd_i.ready = adv_1;
  assign accept      = cmd_i.valid && adv_1;
  assign do_load     = accept && (cmd_i.opcode == OP_LOAD);
  assign do_step     = accept && (cmd_i.opcode == OP_STEP);

  // Bresenham stepper
  lrpw_pix_t            pix;
  logic [ColorBits-1:0] held_color;

  lrpw_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (do_load),
    .step_i          (do_step),
    .start_x_i       (cmd_i.start_x),
    .start_y_i       (cmd_i.start_y),
    .end_x_i         (cmd_i.end_x),
    .end_y_i         (cmd_i.end_y),
    .color_i         (cmd_i.line_color),
    .screen_width_i  (width_q),
    .screen_height_i (height_q),
    .pix_o           (pix),
    .color_o         (held_color)
  );

  // Stage 1: address products
  logic [XprodW-1:0]    xprod_q;
  logic [YprodW-1:0]    yprod_q;
  logic                 inside1_q, done1_q;
  logic [ColorBits-1:0] color1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_1) begin
      v1_q <= do_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      xprod_q   <= XprodW'(pix.pix_x) * XprodW'(bpp_q);
      yprod_q   <= YprodW'(pix.pix_y) * YprodW'(stride_q);
      inside1_q <= pix.in_bounds;
      done1_q   <= pix.line_done;
      color1_q  <= held_color;
    end
  end

  // Output stage: byte address sum, clipped pixels zeroed
  logic [AddrBits-1:0]  addr_d, addr_q;
  logic [ColorBits-1:0] color_q;
  logic                 pvalid_q, done_q;

  assign addr_d = AddrBits'(xprod_q >> ByteShift) + AddrBits'(yprod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv_o) begin
      vo_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && v1_q) begin
      addr_q   <= inside1_q ? addr_d : '0;
      color_q  <= inside1_q ? color1_q : '0;
      pvalid_q <= inside1_q;
      done_q   <= done1_q;
    end
  end

  assign pix_o.valid        = vo_q;
  assign pix_o.byte_address = addr_q;
  assign pix_o.pixel_color  = color_q;
  assign pix_o.pixel_valid  = pvalid_q;
  assign pix_o.line_done    = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lrpw_checker.sv =====
// Port-level checks for the line rasterizer, attached to the top level by bind.
// Depends on line_rasterizer_pixel_writer_unit and lrpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrpw_port_assert (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            cmd_ready,
  input wire logic                            pix_valid,
  input wire logic                            pix_ready,
  input wire logic [lrpw_pkg::AddrBits-1:0]   byte_address,
  input wire logic [lrpw_pkg::ColorBits-1:0]  pixel_color,
  input wire logic                            pixel_valid
);

  // A stalled pixel word stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid && !pix_ready |=> pix_valid)
    else $error("pixel word dropped while stalled");

  // A stalled pixel word keeps its address and color
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid && !pix_ready |=> $stable(byte_address) && $stable(pixel_color))
    else $error("pixel word changed while stalled");

  // Clipped or finished steps carry zero address and color
  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid && !pixel_valid |-> byte_address == '0 && pixel_color == '0)
    else $error("clipped pixel carries address or color");

  // With the output register empty, the block always takes a command
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_valid |-> cmd_ready)
    else $error("command stalled with empty output");

endmodule

bind line_rasterizer_pixel_writer_unit lrpw_port_assert u_lrpw_port_assert (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_ready    (cmd_i.ready),
  .pix_valid    (pix_o.valid),
  .pix_ready    (pix_o.ready),
  .byte_address (pix_o.byte_address),
  .pixel_color  (pix_o.pixel_color),
  .pixel_valid  (pix_o.pixel_valid)
);

`default_nettype wire

// ===== sim/lrpw_checker.sv =====
// Scoreboard for the line rasterizer: follows the register port, predicts each
// pixel word from the command stream, and compares the pixel stream in order.
// Depends on lrpw_pkg and lrpw_if.
`timescale 1ns / 1ps
`default_nettype none

module lrpw_checker
  import lrpw_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lrpw_cmd_if                  cmd_w,
  lrpw_pix_if                  pix_w,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [PaddrBits-1:0] paddr,
  input  logic [PdataBits-1:0] pwdata,
  input  logic [PdataBits-1:0] prdata,
  input  logic                 final_check_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   on_screen_o
);

  localparam int MaxPrinted = 60;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [AddrBits-1:0]  byte_address;
    logic [ColorBits-1:0] pixel_color;
    logic                 pixel_valid;
    logic                 line_done;
  } pixel_word_t;

  // Shadow registers
  logic [ClipBits-1:0]   width_q;
  logic [ClipBits-1:0]   height_q;
  logic [BppBits-1:0]    bpp_q;
  logic [StrideBits-1:0] stride_q;

  // Line state of the predictor
  coord_t               cur_x, cur_y, end_x, end_y;
  longint               span_x, span_y, err_acc;
  logic                 neg_x, neg_y;
  logic [ColorBits-1:0] color_q;

  pixel_word_t pending_pixels[$];
  int          fail_count = 0;
  int          on_screen  = 0;
  int          pixels_seen = 0;
  bit          final_seen = 1'b0;

  assign fail_count_o = fail_count;
  assign on_screen_o  = on_screen;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MaxPrinted) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic logic [PdataBits-1:0] reg_value(input lrpw_reg_e idx);
    case (idx)
      REG_SCREEN_WIDTH:   return PdataBits'(width_q);
      REG_SCREEN_HEIGHT:  return PdataBits'(height_q);
      REG_BITS_PER_PIXEL: return PdataBits'(bpp_q);
      default:            return PdataBits'(stride_q);
    endcase
  endfunction

  // One command word: a load resets the line, a step yields one pixel word
  task automatic rasterize_word(input lrpw_op_e op, input coord_t sx, input coord_t sy,
                                input coord_t ex, input coord_t ey,
                                input logic [ColorBits-1:0] col);
    pixel_word_t       px;
    longint            twice;
    longint unsigned   xu, yu, addr;
    px = '0;
    if (op == OP_LOAD) begin
      cur_x   = sx;
      cur_y   = sy;
      end_x   = ex;
      end_y   = ey;
      span_x  = (ex >= sx) ? longint'(ex) - longint'(sx) : longint'(sx) - longint'(ex);
      span_y  = (ey >= sy) ? longint'(ey) - longint'(sy) : longint'(sy) - longint'(ey);
      neg_x   = ex < sx;
      neg_y   = ey < sy;
      err_acc = span_x - span_y;
      color_q = col;
    end else if (cur_x == end_x && cur_y == end_y) begin
      // nothing left to draw: the point stays put
      px.line_done = 1'b1;
      pending_pixels.push_back(px);
    end else begin
      if (cur_x >= 0 && cur_y >= 0 &&
          longint'(cur_x) < longint'(width_q) && longint'(cur_y) < longint'(height_q)) begin
        xu = 64'(unsigned'(cur_x));
        yu = 64'(unsigned'(cur_y));
        addr = (xu * 64'(bpp_q)) / 8 + yu * 64'(stride_q);
        px.byte_address = addr[AddrBits-1:0];
        px.pixel_color  = color_q;
        px.pixel_valid  = 1'b1;
      end
      // Bresenham step; both tests use the error before the update
      twice = err_acc * 2;
      if (twice > -span_y) begin
        err_acc -= span_y;
        cur_x = neg_x ? cur_x - coord_t'(1) : cur_x + coord_t'(1);
      end
      if (twice < span_x) begin
        err_acc += span_x;
        cur_y = neg_y ? cur_y - coord_t'(1) : cur_y + coord_t'(1);
      end
      px.line_done = (cur_x == end_x && cur_y == end_y);
      pending_pixels.push_back(px);
    end
  endtask

  task automatic compare_pixel(input pixel_word_t got);
    pixel_word_t exp_px;
    pixels_seen++;
    if (pending_pixels.size() == 0) begin
      report_mismatch($sformatf("pixel word %0d arrived with none expected", pixels_seen));
      return;
    end
    exp_px = pending_pixels.pop_front();
    if (got.byte_address !== exp_px.byte_address)
      report_mismatch($sformatf("pixel %0d byte_address %h, expected %h", pixels_seen,
                                got.byte_address, exp_px.byte_address));
    if (got.pixel_color !== exp_px.pixel_color)
      report_mismatch($sformatf("pixel %0d pixel_color %h, expected %h", pixels_seen,
                                got.pixel_color, exp_px.pixel_color));
    if (got.pixel_valid !== exp_px.pixel_valid)
      report_mismatch($sformatf("pixel %0d pixel_valid %b, expected %b", pixels_seen,
                                got.pixel_valid, exp_px.pixel_valid));
    if (got.line_done !== exp_px.line_done)
      report_mismatch($sformatf("pixel %0d line_done %b, expected %b", pixels_seen,
                                got.line_done, exp_px.line_done));
    if (exp_px.pixel_valid) on_screen++;
  endtask

  // Sample every channel at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = ScreenWidthRst;
      height_q = ScreenHeightRst;
      bpp_q    = BppRst;
      stride_q = LineStrideRst;
      cur_x = '0; cur_y = '0; end_x = '0; end_y = '0;
      span_x = 0; span_y = 0; err_acc = 0;
      neg_x = 1'b0; neg_y = 1'b0;
      color_q = '0;
      pending_pixels.delete();
      pending_o = 0;
    end else begin
      // register port
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (lrpw_reg_e'(paddr[3:2]))
            REG_SCREEN_WIDTH:   width_q  = pwdata[ClipBits-1:0];
            REG_SCREEN_HEIGHT:  height_q = pwdata[ClipBits-1:0];
            REG_BITS_PER_PIXEL: bpp_q    = pwdata[BppBits-1:0];
            default:            stride_q = pwdata[StrideBits-1:0];
          endcase
        end else if (prdata !== reg_value(lrpw_reg_e'(paddr[3:2]))) begin
          report_mismatch($sformatf("register %0d read %h, expected %h", paddr[3:2],
                                    prdata, reg_value(lrpw_reg_e'(paddr[3:2]))));
        end
      end
      // pixel words out
      if (pix_w.valid && pix_w.ready)
        compare_pixel('{pix_w.byte_address, pix_w.pixel_color, pix_w.pixel_valid,
                        pix_w.line_done});
      // command words in
      if (cmd_w.valid && cmd_w.ready)
        rasterize_word(cmd_w.opcode, cmd_w.start_x, cmd_w.start_y, cmd_w.end_x,
                       cmd_w.end_y, cmd_w.line_color);
      // leftovers at the end of the run
      if (final_check_i && !final_seen) begin
        final_seen = 1'b1;
        if (pending_pixels.size() != 0)
          report_mismatch($sformatf("%0d expected pixel words never arrived",
                                    pending_pixels.size()));
      end
      pending_o = pending_pixels.size();
    end
  end

endmodule

`default_nettype wire

// ===== sim/line_rasterizer_pixel_writer_unit_tb.sv =====
// Testbench top for line_rasterizer_pixel_writer_unit: drives command words,
// register writes and output back-pressure; lrpw_checker does the comparing.
// Depends on lrpw_pkg, lrpw_if, lrpw_checker and the block itself.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer_pixel_writer_unit_tb;
  import lrpw_pkg::*;

  localparam int unsigned CoordBits = 16;
  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 240;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 6;
  localparam int CycleLimit  = 400000;

  typedef logic signed [CoordBits-1:0] coord_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                 psel, penable, pwrite;
  logic [PaddrBits-1:0] paddr;
  logic [PdataBits-1:0] pwdata, prdata;
  logic                 pready;

  lrpw_cmd_if #(.COORD_BITS(CoordBits)) cmd_w ();
  lrpw_pix_if                            pix_w ();

  int   fail_count, pending, on_screen;
  logic final_check = 1'b0;

  // Idle control shared by the driving processes
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_go = 1'b0;
  logic rx_hold = 1'b0;

  int items_sent = 0;
  int loads_sent = 0;
  int steps_sent = 0;

  // Settings per phase; phase 0 keeps the reset values
  int cfg_width [NumPhases] = '{1024, 640, 8191, 1, 0,     4096,  4096, 100};
  int cfg_height[NumPhases] = '{768,  480, 8191, 1, 0,     4096,  8191, 50};
  int cfg_bpp   [NumPhases] = '{32,   24,  32,   8, 16,    8,     31,   17};
  int cfg_stride[NumPhases] = '{4096, 1920, 65535, 1, 65535, 65535, 1,  4096};

  always #5 clk_i = ~clk_i;

  line_rasterizer_pixel_writer_unit #(.COORD_BITS(CoordBits)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_w),
    .pix_o   (pix_w),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lrpw_checker #(.COORD_BITS(CoordBits)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_w         (cmd_w),
    .pix_w         (pix_w),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .final_check_i (final_check),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .on_screen_o   (on_screen)
  );

  // Output back-pressure
  initial begin
    pix_w.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      pix_w.ready = !rx_hold && (int'($urandom_range(99)) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here
  always begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
    wait (!hold_go);
  end

  // Watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d pixel words outstanding", CycleLimit, pending);
    $display("TEST FAILED");
    $finish;
  end

  // One command word, with random idle cycles before it
  task automatic send_cmd(input lrpw_op_e op, input coord_t sx, input coord_t sy,
                          input coord_t ex, input coord_t ey,
                          input logic [ColorBits-1:0] col);
    forever begin
      @(negedge clk_i);
      if (int'($urandom_range(99)) < send_idle_pct) begin
        cmd_w.valid      = 1'b0;
        cmd_w.opcode     = lrpw_op_e'($urandom_range(1));
        cmd_w.start_x    = coord_t'($urandom);
        cmd_w.line_color = ColorBits'($urandom);
      end else begin
        break;
      end
    end
    cmd_w.valid      = 1'b1;
    cmd_w.opcode     = op;
    cmd_w.start_x    = sx;
    cmd_w.start_y    = sy;
    cmd_w.end_x      = ex;
    cmd_w.end_y      = ey;
    cmd_w.line_color = col;
    do @(posedge clk_i); while (!cmd_w.ready);
    items_sent++;
    if (op == OP_LOAD) loads_sent++;
    else steps_sent++;
  endtask

  // Step word; its other fields are don't-care and get random content
  task automatic send_step();
    send_cmd(OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
             coord_t'($urandom), ColorBits'($urandom));
  endtask

  task automatic send_line(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey, input logic [ColorBits-1:0] col,
                           input int steps);
    send_cmd(OP_LOAD, sx, sy, ex, ey, col);
    repeat (steps) send_step();
  endtask

  // Stop sending and let every expected pixel word come out
  task automatic drain();
    @(negedge clk_i);
    cmd_w.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input lrpw_reg_e idx,
                            input logic [PdataBits-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic program_phase(input int ph);
    apb_access(1'b1, REG_SCREEN_WIDTH,   PdataBits'(cfg_width[ph]));
    apb_access(1'b1, REG_SCREEN_HEIGHT,  PdataBits'(cfg_height[ph]));
    apb_access(1'b1, REG_BITS_PER_PIXEL, PdataBits'(cfg_bpp[ph]));
    apb_access(1'b1, REG_LINE_STRIDE,    PdataBits'(cfg_stride[ph]));
    apb_access(1'b0, REG_SCREEN_WIDTH,   '0);
    apb_access(1'b0, REG_SCREEN_HEIGHT,  '0);
    apb_access(1'b0, REG_BITS_PER_PIXEL, '0);
    apb_access(1'b0, REG_LINE_STRIDE,    '0);
  endtask

  // Coordinate near one screen edge or anywhere on the screen
  function automatic coord_t pick_near(input int limit);
    int v;
    case ($urandom_range(2))
      0:       v = int'($urandom_range(60)) - 30;
      1:       v = limit + int'($urandom_range(60)) - 30;
      default: v = int'($urandom_range(limit));
    endcase
    return coord_t'(v);
  endfunction

  function automatic coord_t nudge(input coord_t c);
    int off;
    if ($urandom_range(9) == 0) off = int'($urandom_range(600)) - 300;
    else off = int'($urandom_range(80)) - 40;
    return coord_t'(int'(c) + off);
  endfunction

  task automatic random_word(input int ph);
    coord_t sx, sy, ex, ey;
    int     kind, dx, dy, steps;
    kind = $urandom_range(99);
    if (kind < 72) begin
      // well-formed line near the screen, drawn to the end and a bit past unless capped at 120 steps
      sx = pick_near(cfg_width[ph]);
      sy = pick_near(cfg_height[ph]);
      ex = nudge(sx);
      ey = nudge(sy);
      dx = int'(ex) - int'(sx);
      dy = int'(ey) - int'(sy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      steps = ((dx > dy) ? dx : dy) + int'($urandom_range(2));
      if (steps > 120) steps = 120;
      send_line(sx, sy, ex, ey, ColorBits'($urandom), steps);
    end else if (kind < 82) begin
      // full-range coordinates, cut short
      send_line(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), ColorBits'($urandom), $urandom_range(10));
    end else if (kind < 90) begin
      // broken sequence: reload before the line is done
      send_line(pick_near(cfg_width[ph]), pick_near(cfg_height[ph]),
                pick_near(cfg_width[ph]), pick_near(cfg_height[ph]),
                ColorBits'($urandom), $urandom_range(5));
    end else begin
      // noise word
      send_cmd(lrpw_op_e'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
               coord_t'($urandom), coord_t'($urandom), ColorBits'($urandom));
    end
  endtask

  task automatic run_phase(input int ph);
    int stop_at, half_at;
    stop_at = items_sent + PhaseItems;
    half_at = items_sent + PhaseItems / 2;
    case (ph % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
    if (ph == 4) hold_go = 1'b1;
    while (items_sent < stop_at) begin
      random_word(ph);
      if (ph == 1 && items_sent >= half_at && half_at > 0) begin
        drain();
        half_at = 0;
      end
    end
    hold_go = 1'b0;
  endtask

  // Directed words under the reset settings
  task automatic directed_words();
    send_step();                                              // step right after reset
    send_line(16'sd5, 16'sd5, 16'sd5, 16'sd5, 24'hFFFFFF, 1); // zero-length line
    send_line(16'sd0, 16'sd0, 16'sd3, 16'sd1, 24'h123456, 4); // shallow line, past end
    send_line(16'sd1023, 16'sd767, 16'sd1026, 16'sd764, 24'hFFFFFF, 4); // leaves screen
    send_line(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 24'h000000, 2);
    send_line(16'sd2, -16'sd2, 16'sd2, 16'sd2, 24'hA5C3F0, 4);  // vertical, starts clipped
    send_line(16'sd10, 16'sd3, 16'sd6, 16'sd3, 24'h0F0F0F, 2);  // horizontal, backwards
  endtask

  // Main stimulus
  initial begin
    rst_ni           = 1'b0;
    cmd_w.valid      = 1'b0;
    cmd_w.opcode     = OP_LOAD;
    cmd_w.start_x    = '0;
    cmd_w.start_y    = '0;
    cmd_w.end_x      = '0;
    cmd_w.end_y      = '0;
    cmd_w.line_color = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    directed_words();
    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        drain();
        program_phase(ph);
      end
      run_phase(ph);
    end

    drain();
    final_check = 1'b1;
    repeat (2) @(negedge clk_i);

    $display("Sent %0d words (%0d line loads, %0d steps) over %0d register settings,",
             items_sent, loads_sent, steps_sent, NumPhases);
    $display("with idle, stall and hold-off phases; %0d pixels landed on screen.", on_screen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
